// File: rtl/core/sorted_table_ternary_search_top_assert.svh
// assertion macros shared by the sorted table ternary search rtl
`ifndef SORTED_TABLE_TERNARY_SEARCH_TOP_ASSERT_SVH
`define SORTED_TABLE_TERNARY_SEARCH_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define STTS_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define STTS_ASSERT_ALWAYS(name, clk, prop, msg) \
	name: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define STTS_ASSERT(name, clk, rst_n, prop, msg)
`define STTS_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

// File: rtl/core/stts_pkg.sv
// types, constants and control structs for the sorted table ternary search
package stts_pkg;

	localparam int TABLE_DEPTH_DEF = 256;
	localparam int KEY_BITS_DEF    = 64;
	localparam int KEY_W           = 64;
	localparam int POS_W           = 8;
	localparam int CNT_W           = 9;

	typedef enum logic {
		CMD_LOAD   = 1'b0,
		CMD_SEARCH = 1'b1
	} command_t;

	typedef struct packed {
		command_t          command;
		logic [POS_W-1:0]  position;
		logic [KEY_W-1:0]  key;
	} req_t;

	typedef struct packed {
		logic              found;
		logic [POS_W-1:0]  match_position;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic start;
		logic mul;
		logic miss;
		logic probe;
		logic step;
		logic emit;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic live;
		logic hit;
		logic out_busy;
	} ctl_sts_t;

endpackage

// File: rtl/core/stts_ctrl.sv
// search sequencer: issues table loads and steps the datapath through the rounds of one search
`include "sorted_table_ternary_search_top_assert.svh"

module stts_ctrl
	import stts_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	input  command_t req_command,
	output logic     req_stall,
	output ctl_cmd_t cmd,
	input  ctl_sts_t sts
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_PROBE,
		ST_CMP,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   stall_q;

	assign req_stall = stall_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.start = req_valid && (req_command == CMD_SEARCH);
				cmd.load  = req_valid && (req_command == CMD_LOAD);
			end
			ST_CHECK: begin
				cmd.mul  = sts.live;
				cmd.miss = !sts.live;
			end
			ST_PROBE: begin
				cmd.probe = 1'b1;
			end
			ST_CMP: begin
				cmd.step = 1'b1;
			end
			ST_DONE: begin
				cmd.emit = !sts.out_busy;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			stall_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						state_q <= ST_CHECK;
						stall_q <= 1'b1;
					end
				end
				ST_CHECK: begin
					state_q <= sts.live ? ST_PROBE : ST_DONE;
				end
				ST_PROBE: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					state_q <= sts.hit ? ST_DONE : ST_CHECK;
				end
				ST_DONE: begin
					if (cmd.emit) begin
						state_q <= ST_IDLE;
						stall_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					stall_q <= 1'b0;
				end
			endcase
		end
	end

	`STTS_ASSERT(a_stall_tracks_state, clk, arst_n, stall_q == (state_q != ST_IDLE), "stall out of step with sequencer state")
	`STTS_ASSERT(a_emit_needs_slot, clk, arst_n, cmd.emit |-> !sts.out_busy, "result emitted over an untaken result")
	`STTS_ASSERT(a_start_enters_check, clk, arst_n, cmd.start |=> state_q == ST_CHECK, "search start did not enter the first round")
	`STTS_ASSERT_ALWAYS(a_one_cmd, clk, $onehot0(cmd), "more than one datapath command at once")

endmodule

// File: rtl/core/stts_dp.sv
// search datapath: key table, range registers, third split, compare and result register
`include "sorted_table_ternary_search_top_assert.svh"

module stts_dp
	import stts_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int KEY_BITS    = KEY_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  req_t             req,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CNT_W-1:0] cfg_data,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output rsp_t             rsp,
	input  ctl_cmd_t         cmd,
	output ctl_sts_t         sts
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int PW    = IDX_W + 2;
	// floor(n / 3) as (n * RECIP) >> SH, exact for every n below 2**IDX_W
	localparam int SH    = IDX_W + 2;
	localparam int MW    = IDX_W + SH;
	localparam int RECIP = ((2 ** SH) + 2) / 3;

	logic [KEY_BITS-1:0] mem [TABLE_DEPTH];

	logic [CNT_W-1:0]     entry_count_q;
	logic [KEY_BITS-1:0]  key_q;
	logic signed [PW-1:0] left_q;
	logic signed [PW-1:0] right_q;
	logic signed [PW-1:0] lo_q;
	logic signed [PW-1:0] hi_q;
	logic [MW-1:0]        mul_q;
	logic [KEY_BITS-1:0]  lo_key_q;
	logic [KEY_BITS-1:0]  hi_key_q;
	logic                 rsp_valid_q;
	rsp_t                 rsp_q;
	logic                 found_q;
	logic [POS_W-1:0]     pos_q;

	logic [PW-1:0]        cnt_c;
	logic [IDX_W-1:0]     span_c;
	logic [IDX_W-1:0]     third_c;
	logic signed [PW-1:0] lo_c;
	logic signed [PW-1:0] hi_c;
	logic                 lo_eq;
	logic                 hi_eq;
	logic                 wr_en;

	assign cfg_ready = 1'b1;

	always_comb begin
		if (32'(entry_count_q) > 32'(TABLE_DEPTH)) begin
			cnt_c = PW'(TABLE_DEPTH);
		end else begin
			cnt_c = PW'(entry_count_q);
		end
	end

	// range is live here, so right - left is never negative
	assign span_c  = IDX_W'(right_q - left_q);
	assign third_c = mul_q[MW-1:SH];
	assign lo_c    = left_q + $signed({2'b00, third_c});
	assign hi_c    = right_q - $signed({2'b00, third_c});

	assign lo_eq = (lo_key_q == key_q);
	assign hi_eq = (hi_key_q == key_q);
	assign wr_en = cmd.load && (32'(req.position) < 32'(TABLE_DEPTH));

	assign sts.live     = (left_q <= right_q);
	assign sts.hit      = lo_eq || hi_eq;
	assign sts.out_busy = rsp_valid_q && rsp_stall;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[IDX_W'(req.position)] <= req.key[KEY_BITS-1:0];
		end
		if (cmd.probe) begin
			lo_key_q <= mem[lo_c[IDX_W-1:0]];
			hi_key_q <= mem[hi_c[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			key_q   <= req.key[KEY_BITS-1:0];
			left_q  <= '0;
			right_q <= $signed(cnt_c - PW'(1));
		end
		if (cmd.mul) begin
			mul_q <= MW'(span_c) * MW'(RECIP);
		end
		if (cmd.probe) begin
			lo_q <= lo_c;
			hi_q <= hi_c;
		end
		if (cmd.step) begin
			// lower probe wins when both match
			if (lo_eq) begin
				found_q <= 1'b1;
				pos_q   <= POS_W'(lo_q[IDX_W-1:0]);
			end else if (hi_eq) begin
				found_q <= 1'b1;
				pos_q   <= POS_W'(hi_q[IDX_W-1:0]);
			end else if (key_q < lo_key_q) begin
				right_q <= lo_q - PW'(1);
			end else if (key_q > hi_key_q) begin
				left_q <= hi_q + PW'(1);
			end else begin
				left_q  <= lo_q + PW'(1);
				right_q <= hi_q - PW'(1);
			end
		end
		if (cmd.miss) begin
			found_q <= 1'b0;
			pos_q   <= '0;
		end
		if (cmd.emit) begin
			rsp_q.found          <= found_q;
			rsp_q.match_position <= pos_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
			rsp_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				entry_count_q <= cfg_data;
			end
			if (cmd.emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`STTS_ASSERT(a_probes_ordered, clk, arst_n, cmd.probe |=> (lo_q <= hi_q) && (lo_q >= left_q) && (hi_q <= right_q), "probe points outside the live range")
	`STTS_ASSERT(a_mul_when_live, clk, arst_n, cmd.mul |-> sts.live, "third split started on an empty range")

endmodule

// File: rtl/core/sorted_table_ternary_search_top.sv
// top level of the sorted table ternary search block
//
//  channel | handshake             | payload   | moves
//  req     | req_valid / req_stall | req_t     | load or search command
//  rsp     | rsp_valid / rsp_stall | rsp_t     | one result per search
//  cfg     | cfg_valid / cfg_ready | cfg_data  | entry_count write
//
// a load is one transfer; the table write happens at the req transfer
// a search of R rounds (split, two-port table read, compare) stalls req until its result is
// emitted, a miss after one more range check; R <= 6 for 256 entries
// one item at a time; a finished result waits in the rsp register while the next item enters
// arst_n clears the sequencer, entry_count and rsp_valid; the table is not cleared
// a stalled rsp only holds the next search in its done state, before its result is emitted

module sorted_table_ternary_search_top
	import stts_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int KEY_BITS    = KEY_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  req_t             req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output rsp_t             rsp,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CNT_W-1:0] cfg_data
);

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	stts_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_command (req.command),
		.req_stall   (req_stall),
		.cmd         (cmd),
		.sts         (sts)
	);

	stts_dp #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.KEY_BITS    (KEY_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

// File: sim/tb_top.sv
// testbench for the sorted table ternary search: every result checked against a predicted search
`timescale 1ns / 1ps

module tb_top;
	import stts_pkg::*;

	localparam int DEPTH        = 256;
	localparam int MAX_GAP      = 17;
	localparam int DRAIN_CYCLES = 40;
	localparam int RANDOM_ITEMS = 380;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             req_valid;
	logic             req_stall;
	req_t             req;
	logic             rsp_valid;
	logic             rsp_stall;
	rsp_t             rsp;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CNT_W-1:0] cfg_data;

	logic [KEY_W-1:0] key_model [DEPTH];
	int unsigned      count_model;
	rsp_t             pending_rsp [$];
	int unsigned      error_count;
	int unsigned      items_sent;
	bit               quiet;

	sorted_table_ternary_search_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	function automatic int unsigned pick_gap();
		return quiet ? 0 : $urandom_range(0, MAX_GAP);
	endfunction

	function automatic int live_count();
		return (count_model > DEPTH) ? DEPTH : int'(count_model);
	endfunction

	function automatic logic [KEY_W-1:0] random_key();
		return {$urandom, $urandom};
	endfunction

	function automatic rsp_t predict_search(logic [KEY_W-1:0] target);
		int   left_b;
		int   right_b;
		int   third;
		int   lo_probe;
		int   hi_probe;
		rsp_t result;
		result  = '0;
		left_b  = 0;
		right_b = live_count() - 1;
		while (left_b <= right_b) begin
			third    = (right_b - left_b) / 3;
			lo_probe = left_b + third;
			hi_probe = right_b - third;
			// lower probe wins on duplicates
			if (key_model[lo_probe] == target) begin
				result.found          = 1'b1;
				result.match_position = lo_probe[POS_W-1:0];
				return result;
			end
			if (key_model[hi_probe] == target) begin
				result.found          = 1'b1;
				result.match_position = hi_probe[POS_W-1:0];
				return result;
			end
			if (target < key_model[lo_probe]) begin
				right_b = lo_probe - 1;
			end else if (target > key_model[hi_probe]) begin
				left_b = hi_probe + 1;
			end else begin
				left_b  = lo_probe + 1;
				right_b = hi_probe - 1;
			end
		end
		return result;
	endfunction

	task automatic send_item(command_t cmd, logic [POS_W-1:0] pos, logic [KEY_W-1:0] k);
		int unsigned gap;
		req_t        item;
		gap           = pick_gap();
		item.command  = cmd;
		item.position = pos;
		item.key      = k;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req       <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		items_sent++;
		if (cmd == CMD_LOAD) begin
			key_model[pos] = k;
		end else begin
			pending_rsp.push_back(predict_search(k));
		end
	endtask

	task automatic write_count(int unsigned value);
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		// loads leave nothing to wait on, so give the block time to settle
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_data  <= value[CNT_W-1:0];
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid   <= 1'b0;
		count_model = value & 32'h1FF;
	endtask

	// non-decreasing keys at positions 0..n-1, larger shift gives denser keys
	task automatic fill_sorted(int unsigned n, int unsigned shift);
		logic [KEY_W-1:0] k;
		logic [KEY_W-1:0] nxt;
		logic [KEY_W-1:0] inc;
		k = random_key() >> shift;
		for (int i = 0; i < n; i++) begin
			send_item(CMD_LOAD, i[POS_W-1:0], k);
			inc = ($urandom_range(0, 7) == 0) ? '0 : (random_key() >> shift);
			nxt = k + inc;
			k   = (nxt < k) ? '1 : nxt;
		end
	endtask

	task automatic search_mix(int unsigned n);
		logic [KEY_W-1:0] target;
		int               cnt;
		cnt = live_count();
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 5)) inside
				[0:2]: begin
					target = (cnt > 0) ? key_model[$urandom_range(0, cnt - 1)] : random_key();
				end
				3: begin
					target = (cnt > 0) ? key_model[$urandom_range(0, cnt - 1)] : random_key();
					target = $urandom_range(0, 1) ? target + 1 : target - 1;
				end
				4: begin
					target = $urandom_range(0, 1) ? '1 : '0;
				end
				default: begin
					target = random_key();
				end
			endcase
			send_item(CMD_SEARCH, POS_W'($urandom), target);
		end
	endtask

	task automatic test_empty_table();
		write_count(0);
		send_item(CMD_SEARCH, '0, '0);
		send_item(CMD_SEARCH, '1, '1);
		send_item(CMD_SEARCH, 8'h5A, 64'hA5A5_5A5A_0F0F_F0F0);
	endtask

	task automatic test_small_table();
		send_item(CMD_LOAD, 8'd0, 64'd5);
		send_item(CMD_LOAD, 8'd1, 64'd9);
		send_item(CMD_LOAD, 8'd2, 64'd9);
		write_count(1);
		send_item(CMD_SEARCH, '0, 64'd5);
		send_item(CMD_SEARCH, '0, 64'd4);
		send_item(CMD_SEARCH, '0, 64'd6);
		write_count(3);
		// duplicate keys at positions 1 and 2
		send_item(CMD_SEARCH, '0, 64'd9);
		send_item(CMD_SEARCH, '0, 64'd5);
		send_item(CMD_SEARCH, '0, 64'd8);
		send_item(CMD_SEARCH, '0, 64'd10);
		write_count(2);
		send_item(CMD_SEARCH, '1, 64'd9);
	endtask

	task automatic test_full_table();
		fill_sorted(DEPTH, 8);
		send_item(CMD_LOAD, 8'd0, '0);
		send_item(CMD_LOAD, 8'd255, '1);
		write_count(256);
		send_item(CMD_SEARCH, '0, '0);
		send_item(CMD_SEARCH, '0, '1);
		send_item(CMD_SEARCH, '0, key_model[128]);
		send_item(CMD_SEARCH, '0, key_model[128] + 1);
		send_item(CMD_SEARCH, '0, key_model[77] - 1);
		// count above depth is clamped
		write_count(511);
		send_item(CMD_SEARCH, '0, '1);
		send_item(CMD_SEARCH, '0, key_model[200]);
		write_count(255);
		send_item(CMD_SEARCH, '0, '1);
		send_item(CMD_SEARCH, '0, key_model[254]);
	endtask

	task automatic test_unsorted_table();
		logic [KEY_W-1:0] k;
		for (int i = 0; i < 8; i++) begin
			k = random_key();
			send_item(CMD_LOAD, POS_W'($urandom), k);
		end
		write_count(256);
		search_mix(12);
		write_count($urandom_range(1, 255));
		search_mix(8);
	endtask

	task automatic test_random();
		int unsigned start;
		int unsigned count_pick;
		start = items_sent;
		while (items_sent - start < RANDOM_ITEMS) begin
			quiet = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 9))
				0:       count_pick = $urandom_range(257, 511);
				1:       count_pick = 256;
				default: count_pick = $urandom_range(0, 48);
			endcase
			if (count_pick <= 48 || $urandom_range(0, 3) == 0) begin
				fill_sorted((count_pick > DEPTH) ? DEPTH : count_pick, $urandom_range(8, 62));
			end
			// out of order loads break the sorted order now and then
			if ($urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(1, 4)) begin
					send_item(CMD_LOAD, POS_W'($urandom), random_key());
				end
			end
			write_count(count_pick);
			search_mix($urandom_range(10, 30));
		end
		quiet = 1'b0;
	endtask

	initial begin : rsp_monitor
		rsp_t        want;
		int unsigned gap;
		rsp_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = pick_gap();
			if (gap > 0) begin
				rsp_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (rsp_valid !== 1'b1);
			if (pending_rsp.size() == 0) begin
				$display("%0t unexpected transfer: expected none, actual found=%0b pos=%0d",
					$time, rsp.found, rsp.match_position);
				error_count++;
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.found !== want.found || rsp.match_position !== want.match_position) begin
					$display("%0t mismatch: expected found=%0b pos=%0d, actual found=%0b pos=%0d",
						$time, want.found, want.match_position, rsp.found, rsp.match_position);
					error_count++;
				end
			end
		end
	end

	initial begin
		arst_n      <= 1'b0;
		req_valid   <= 1'b0;
		req         <= '0;
		cfg_valid   <= 1'b0;
		cfg_data    <= '0;
		count_model = 0;
		error_count = 0;
		items_sent  = 0;
		quiet       = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_small_table();
		test_full_table();
		test_unsorted_table();
		test_random();
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("tb_top: errors");
		$finish;
	end

endmodule
